>>> rtl/ga_pkg.sv
package ga_pkg;

   // request codes
   localparam logic [1:0] REQ_LOAD    = 2'd0;
   localparam logic [1:0] REQ_SET_FIT = 2'd1;
   localparam logic [1:0] REQ_EVOLVE  = 2'd2;
   localparam logic [1:0] REQ_READ    = 2'd3;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ELITISM   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOURNAMENT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MUT_THR   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED      = 2'd3;

   localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
   localparam int LFSR_STEPS_PER_CYCLE = 8;

   // Galois right-shift LFSR, eight steps
   function automatic logic [31:0] lfsr_advance(input logic [31:0] s);
      logic [31:0] x;
      x = s;
      for (int k = 0; k < LFSR_STEPS_PER_CYCLE; k++) begin
         if (x[0]) begin
            x = (x >> 1) ^ LFSR_MASK;
         end else begin
            x = x >> 1;
         end
      end
      return x;
   endfunction

endpackage

>>> rtl/ga_lfsr.sv
module ga_lfsr (
   input  logic        clock,
   input  logic        reset,
   input  logic        seed_load,
   input  logic [31:0] seed,
   input  logic        step,
   output logic [31:0] state
);
   import ga_pkg::*;

   logic [31:0] lfsr_ff;
   logic [31:0] lfsr_in;

   always_comb begin
      lfsr_in = lfsr_ff;
      if (seed_load) begin
         lfsr_in = (seed == 32'd0) ? 32'd1 : seed;
      end else if (step) begin
         lfsr_in = lfsr_advance(lfsr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= 32'd1;
      end else begin
         lfsr_ff <= lfsr_in;
      end
   end

   assign state = lfsr_ff;

endmodule

>>> rtl/ga_fit_cmp.sv
module ga_fit_cmp (
   input  logic signed [31:0] fit_a,
   input  logic signed [31:0] fit_b,
   input  logic               force_take,
   output logic               take_b
);
   import ga_pkg::*;

   // b replaces a on ties: later index wins
   assign take_b = force_take | (fit_a <= fit_b);

endmodule

>>> rtl/ga_generation_engine.sv
// GA generation engine.
// Request channel (req_*): valid/ready. req_type selects load genes, set
// fitness, evolve one generation or read a member. Load and set fitness
// finish in the accept cycle and return nothing. Read returns one
// registered response in the cycle after accept. Evolve returns POP_SIZE
// responses, slots 0 upward, rsp_last on the final one.
// Response channel (rsp_*): valid/ready, one output register. A stalled
// response holds its payload; the engine waits and takes no new request
// until every response of the current request has been taken.
// Config channel (csr_*): always ready; the user must write it only
// while idle; the block does not enforce this. Evolve cost: each draw
// takes sixteen LFSR steps, then uses the low half. Per bred slot
// 2*T + GENE_COUNT draws, GENE_COUNT mutation tests and one draw per
// mutated gene; plus a POP_SIZE elitism scan and a handshake per response.
// One LFSR serves all draws, one comparator the scan and tournaments.
// Reset: LFSR to 1, registers to their defaults, engine idle. Population
// contents are undefined until loaded.
module ga_generation_engine #(
   parameter int POP_SIZE       = 10,
   parameter int MAX_TOURNAMENT = 5,
   parameter int GENE_COUNT     = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_type,
   input  logic [3:0]                     req_member_index,
   input  logic signed [15:0]             req_gene_x,
   input  logic signed [15:0]             req_gene_y,
   input  logic signed [31:0]             req_fitness_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [3:0]                     rsp_out_index,
   output logic signed [15:0]             rsp_out_gene_x,
   output logic signed [15:0]             rsp_out_gene_y,
   output logic signed [31:0]             rsp_out_fitness,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ga_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                    csr_wdata
);
   import ga_pkg::*;

   localparam int IW = (POP_SIZE > 1) ? $clog2(POP_SIZE) : 1;
   localparam int TW = $clog2(MAX_TOURNAMENT + 1);
   localparam int GW = (GENE_COUNT > 1) ? $clog2(GENE_COUNT) : 1;
   localparam int GY = (GENE_COUNT > 1) ? 1 : 0;
   localparam logic [IW-1:0] LAST_SLOT = IW'(POP_SIZE - 1);
   localparam logic [GW-1:0] LAST_GENE = GW'(GENE_COUNT - 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_ELITE = 4'd2;
   localparam logic [3:0] S_TDRAW = 4'd3;
   localparam logic [3:0] S_XDRAW = 4'd4;
   localparam logic [3:0] S_MTEST = 4'd5;
   localparam logic [3:0] S_MADD  = 4'd6;
   localparam logic [3:0] S_EMIT  = 4'd7;
   localparam logic [3:0] S_EWAIT = 4'd8;
   localparam logic [3:0] S_RSP   = 4'd9;

   // population and generation under construction
   logic [15:0] pop_genes    [POP_SIZE][GENE_COUNT];
   logic [31:0] pop_fitness  [POP_SIZE];
   logic [15:0] next_genes   [POP_SIZE][GENE_COUNT];
   logic [31:0] next_fitness [POP_SIZE];

   // config
   logic        elitism_ff;
   logic [2:0]  tsize_ff;
   logic [15:0] mut_thr_ff;

   // control
   logic [3:0]    state_ff, state_in;
   logic [1:0]    phase_ff, phase_in;
   logic [IW-1:0] slot_ff, slot_in;
   logic [GW-1:0] gene_ff, gene_in;
   logic [TW-1:0] tcnt_ff, tcnt_in;
   logic          par_ff, par_in;
   logic [IW-1:0] best_ff, best_in;
   logic [31:0]   best_fit_ff, best_fit_in;
   logic [IW-1:0] p1_ff, p1_in;
   logic [IW-1:0] p2_ff, p2_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // response payload
   logic [3:0]  rsp_idx_ff;
   logic [15:0] rsp_gx_ff, rsp_gy_ff;
   logic [31:0] rsp_fit_ff;
   logic        rsp_last_ff;

   logic [31:0]   lfsr_state;
   logic [15:0]   rnd;
   logic          draw_state, draw_ready, lfsr_step, seed_load;
   logic [IW+16:0] pick_prod;
   logic [IW-1:0] pick, xsel;
   logic [IW-1:0] pf_addr, pg_addr;
   logic [31:0]   rd_fit;
   logic [15:0]   rd_genes [GENE_COUNT];
   logic          take_b, force_take;
   logic [TW-1:0] tn_eff;
   logic          req_fire, in_range, csr_fire;
   logic [IW-1:0] req_idx;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;
   assign in_range  = (int'(req_member_index) < POP_SIZE);
   assign req_idx   = req_member_index[IW-1:0];

   // one draw: LFSR advances in phases 0 and 1, then phase 2 uses the value
   assign draw_state = (state_ff == S_TDRAW) || (state_ff == S_XDRAW) ||
                       (state_ff == S_MTEST) || (state_ff == S_MADD);
   assign draw_ready = draw_state && (phase_ff == 2'd2);
   assign lfsr_step  = draw_state && (phase_ff != 2'd2);
   assign seed_load  = csr_fire && (csr_index == CSR_SEED);
   assign rnd        = lfsr_state[15:0];

   ga_lfsr u_lfsr (
      .clock     (clock),
      .reset     (reset),
      .seed_load (seed_load),
      .seed      (csr_wdata),
      .step      (lfsr_step),
      .state     (lfsr_state)
   );

   // member pick: (r * POP_SIZE) >> 16
   assign pick_prod = {{(IW+1){1'b0}}, rnd} * (IW+17)'(POP_SIZE);
   assign pick      = pick_prod[IW+15:16];
   assign xsel      = rnd[0] ? p2_ff : p1_ff;

   // effective tournament size, clamped to 1..MAX_TOURNAMENT
   always_comb begin
      if (tsize_ff == 3'd0) begin
         tn_eff = TW'(1);
      end else if (int'(tsize_ff) > MAX_TOURNAMENT) begin
         tn_eff = TW'(MAX_TOURNAMENT);
      end else begin
         tn_eff = TW'(tsize_ff);
      end
   end

   // single read port per population array
   always_comb begin
      unique case (state_ff)
         S_SCAN:  pf_addr = slot_ff;
         S_TDRAW: pf_addr = pick;
         default: pf_addr = req_idx;
      endcase
      unique case (state_ff)
         S_ELITE: pg_addr = best_ff;
         S_XDRAW: pg_addr = xsel;
         default: pg_addr = req_idx;
      endcase
   end

   assign rd_fit = pop_fitness[pf_addr];
   always_comb begin
      for (int g = 0; g < GENE_COUNT; g++) begin
         rd_genes[g] = pop_genes[pg_addr][g];
      end
   end

   // shared fitness comparator: scan and tournaments
   assign force_take = (state_ff == S_SCAN) ? (slot_ff == '0) : (tcnt_ff == '0);

   ga_fit_cmp u_cmp (
      .fit_a      (best_fit_ff),
      .fit_b      (rd_fit),
      .force_take (force_take),
      .take_b     (take_b)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      slot_in      = slot_ff;
      gene_in      = gene_ff;
      tcnt_in      = tcnt_ff;
      par_in       = par_ff;
      best_in      = best_ff;
      best_fit_in  = best_fit_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      rsp_valid_in = rsp_valid_ff;
      if (lfsr_step) begin
         phase_in = phase_ff + 2'd1;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               phase_in = 2'd0;
               tcnt_in  = '0;
               par_in   = 1'b0;
               gene_in  = '0;
               slot_in  = '0;
               if (req_type == REQ_READ) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_RSP;
               end else if (req_type == REQ_EVOLVE) begin
                  if (elitism_ff) begin
                     state_in = S_SCAN;
                  end else begin
                     state_in = S_TDRAW;
                  end
               end
            end
         end
         S_SCAN: begin
            if (take_b) begin
               best_in     = slot_ff;
               best_fit_in = rd_fit;
            end
            if (slot_ff == LAST_SLOT) begin
               state_in = S_ELITE;
            end else begin
               slot_in = slot_ff + IW'(1);
            end
         end
         S_ELITE: begin
            slot_in  = IW'(1);
            state_in = S_TDRAW;
         end
         S_TDRAW: begin
            if (draw_ready) begin
               phase_in = 2'd0;
               if (take_b) begin
                  best_in     = pick;
                  best_fit_in = rd_fit;
               end
               if (tcnt_ff == tn_eff - TW'(1)) begin
                  tcnt_in = '0;
                  if (!par_ff) begin
                     p1_in  = take_b ? pick : best_ff;
                     par_in = 1'b1;
                  end else begin
                     p2_in    = take_b ? pick : best_ff;
                     par_in   = 1'b0;
                     gene_in  = '0;
                     state_in = S_XDRAW;
                  end
               end else begin
                  tcnt_in = tcnt_ff + TW'(1);
               end
            end
         end
         S_XDRAW: begin
            if (draw_ready) begin
               phase_in = 2'd0;
               if (gene_ff == LAST_GENE) begin
                  gene_in = '0;
                  if (slot_ff == LAST_SLOT) begin
                     slot_in  = elitism_ff ? IW'(1) : '0;
                     state_in = S_MTEST;
                  end else begin
                     slot_in  = slot_ff + IW'(1);
                     state_in = S_TDRAW;
                  end
               end else begin
                  gene_in = gene_ff + GW'(1);
               end
            end
         end
         S_MTEST, S_MADD: begin
            if (draw_ready) begin
               phase_in = 2'd0;
               if ((state_ff == S_MTEST) && (rnd < mut_thr_ff)) begin
                  state_in = S_MADD;
               end else begin
                  state_in = S_MTEST;
                  if (gene_ff == LAST_GENE) begin
                     gene_in = '0;
                     if (slot_ff == LAST_SLOT) begin
                        slot_in  = '0;
                        state_in = S_EMIT;
                     end else begin
                        slot_in = slot_ff + IW'(1);
                     end
                  end else begin
                     gene_in = gene_ff + GW'(1);
                  end
               end
            end
         end
         S_EMIT: begin
            rsp_valid_in = 1'b1;
            state_in     = S_EWAIT;
         end
         S_EWAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (slot_ff == LAST_SLOT) begin
                  state_in = S_IDLE;
               end else begin
                  slot_in  = slot_ff + IW'(1);
                  state_in = S_EMIT;
               end
            end
         end
         S_RSP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= 2'd0;
         slot_ff      <= '0;
         gene_ff      <= '0;
         tcnt_ff      <= '0;
         par_ff       <= 1'b0;
         best_ff      <= '0;
         p1_ff        <= '0;
         p2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         elitism_ff   <= 1'b1;
         tsize_ff     <= 3'd5;
         mut_thr_ff   <= 16'd983;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         slot_ff      <= slot_in;
         gene_ff      <= gene_in;
         tcnt_ff      <= tcnt_in;
         par_ff       <= par_in;
         best_ff      <= best_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_fire) begin
            unique case (csr_index)
               CSR_ELITISM:    elitism_ff <= csr_wdata[0];
               CSR_TOURNAMENT: tsize_ff   <= csr_wdata[2:0];
               CSR_MUT_THR:    mut_thr_ff <= csr_wdata[15:0];
               CSR_SEED:       ;
               default:        ;
            endcase
         end
      end
   end

   // storage and response payload
   always_ff @(posedge clock) begin
      best_fit_ff <= best_fit_in;
      if (req_fire && in_range && (req_type == REQ_LOAD)) begin
         for (int g = 0; g < GENE_COUNT; g++) begin
            if (g == 0) begin
               pop_genes[req_idx][g] <= req_gene_x;
            end else if (g == 1) begin
               pop_genes[req_idx][g] <= req_gene_y;
            end else begin
               pop_genes[req_idx][g] <= 16'd0;
            end
         end
      end
      if (req_fire && in_range && (req_type == REQ_SET_FIT)) begin
         pop_fitness[req_idx] <= req_fitness_value;
      end
      if (req_fire && (req_type == REQ_READ)) begin
         rsp_idx_ff  <= req_member_index;
         rsp_gx_ff   <= in_range ? rd_genes[0] : 16'd0;
         rsp_gy_ff   <= (in_range && (GENE_COUNT > 1)) ? rd_genes[GY] : 16'd0;
         rsp_fit_ff  <= in_range ? rd_fit : 32'd0;
         rsp_last_ff <= 1'b1;
      end
      if (state_ff == S_ELITE) begin
         for (int g = 0; g < GENE_COUNT; g++) begin
            next_genes[0][g] <= rd_genes[g];
         end
         next_fitness[0] <= best_fit_ff;
      end
      if ((state_ff == S_XDRAW) && draw_ready) begin
         next_genes[slot_ff][gene_ff] <= rd_genes[gene_ff];
         next_fitness[slot_ff]        <= 32'd0;
      end
      if ((state_ff == S_MADD) && draw_ready) begin
         next_genes[slot_ff][gene_ff] <= next_genes[slot_ff][gene_ff] + {15'd0, rnd[0]};
      end
      if (state_ff == S_EMIT) begin
         // commit the new member and present it
         for (int g = 0; g < GENE_COUNT; g++) begin
            pop_genes[slot_ff][g] <= next_genes[slot_ff][g];
         end
         pop_fitness[slot_ff] <= next_fitness[slot_ff];
         rsp_idx_ff  <= 4'(slot_ff);
         rsp_gx_ff   <= next_genes[slot_ff][0];
         rsp_gy_ff   <= (GENE_COUNT > 1) ? next_genes[slot_ff][GY] : 16'd0;
         rsp_fit_ff  <= next_fitness[slot_ff];
         rsp_last_ff <= (slot_ff == LAST_SLOT);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_index   = rsp_idx_ff;
   assign rsp_out_gene_x  = rsp_gx_ff;
   assign rsp_out_gene_y  = rsp_gy_ff;
   assign rsp_out_fitness = rsp_fit_ff;
   assign rsp_last        = rsp_last_ff;

   // checks
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_RSP) || (state_ff == S_EWAIT))
      else $error("response valid outside a response state");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid_ff))
      else $error("request taken while a response is pending");

   a_phase: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("draw phase out of range");

   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (state_ff == S_EWAIT)) |->
         (rsp_last_ff == (slot_ff == LAST_SLOT)))
      else $error("last flag does not match final slot");

endmodule

>>> sim/ga_generation_engine_tb.sv
module ga_generation_engine_tb;
   import ga_pkg::*;

   localparam int NSLOT = 10;

   // one request as driven on the req_ channel
   typedef struct packed {
      logic [1:0]         kind;
      logic [3:0]         slot;
      logic [15:0]        gx;
      logic [15:0]        gy;
      logic [31:0]        fit;
   } ga_req_t;

   // one member report as seen on the rsp_ channel
   typedef struct packed {
      logic [3:0]         slot;
      logic [15:0]        gx;
      logic [15:0]        gy;
      logic [31:0]        fit;
      logic               last;
   } member_rpt_t;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [1:0] req_type;
   logic [3:0] req_member_index;
   logic signed [15:0] req_gene_x, req_gene_y;
   logic signed [31:0] req_fitness_value;
   logic rsp_valid, rsp_ready;
   logic [3:0] rsp_out_index;
   logic signed [15:0] rsp_out_gene_x, rsp_out_gene_y;
   logic signed [31:0] rsp_out_fitness;
   logic rsp_last;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0] csr_wdata;

   ga_generation_engine dut (.*);

   // requests waiting for the driver, reports waiting for the DUT
   ga_req_t     pending_reqs[$];
   member_rpt_t expected_members[$];
   int          mismatches = 0;
   logic        req_taken;
   int          idle_pct = 0;
   int          stall_pct = 0;

   // shadow population, next generation and random source
   logic [15:0] shadow_gx[NSLOT], shadow_gy[NSLOT];
   logic [31:0] shadow_fit[NSLOT];
   logic [15:0] bred_gx[NSLOT], bred_gy[NSLOT];
   logic [31:0] bred_fit[NSLOT];
   logic [31:0] shadow_lfsr;
   logic        keep_elite;
   logic [2:0]  tourney_draws;
   logic [15:0] mut_thresh;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // sixteen Galois steps, low half is the draw
   function automatic logic [15:0] next_draw();
      for (int k = 0; k < 16; k++) begin
         if (shadow_lfsr[0]) begin
            shadow_lfsr = (shadow_lfsr >> 1) ^ 32'h8020_0003;
         end else begin
            shadow_lfsr = shadow_lfsr >> 1;
         end
      end
      return shadow_lfsr[15:0];
   endfunction

   function automatic bit fit_no_better(logic [31:0] a, logic [31:0] b);
      return $signed(a) <= $signed(b);
   endfunction

   // fittest of n draws with replacement, ties to the later draw
   function automatic int tournament_winner();
      int n, champ, pick;
      logic [31:0] r;
      n = (tourney_draws == 0) ? 1 : (tourney_draws > 5 ? 5 : tourney_draws);
      champ = 0;
      for (int k = 0; k < n; k++) begin
         r = {16'd0, next_draw()};
         pick = int'((r * NSLOT) >> 16);
         if (k == 0 || fit_no_better(shadow_fit[champ], shadow_fit[pick])) champ = pick;
      end
      return champ;
   endfunction

   function automatic void predict_members(ga_req_t q);
      int first, champ, p1, p2;
      member_rpt_t m;
      case (q.kind)
         REQ_LOAD: begin
            if (q.slot < NSLOT) begin
               shadow_gx[q.slot] = q.gx;
               shadow_gy[q.slot] = q.gy;
            end
         end
         REQ_SET_FIT: begin
            if (q.slot < NSLOT) shadow_fit[q.slot] = q.fit;
         end
         REQ_READ: begin
            // out-of-range read answers zeros
            if (q.slot < NSLOT) begin
               m = '{q.slot, shadow_gx[q.slot], shadow_gy[q.slot], shadow_fit[q.slot], 1'b1};
            end else begin
               m = '{q.slot, 16'd0, 16'd0, 32'd0, 1'b1};
            end
            expected_members.push_back(m);
         end
         default: begin
            first = 0;
            if (keep_elite) begin
               champ = 0;
               for (int i = 0; i < NSLOT; i++)
                  if (fit_no_better(shadow_fit[champ], shadow_fit[i])) champ = i;
               bred_gx[0] = shadow_gx[champ];
               bred_gy[0] = shadow_gy[champ];
               bred_fit[0] = shadow_fit[champ];
               first = 1;
            end
            for (int i = first; i < NSLOT; i++) begin
               p1 = tournament_winner();
               p2 = tournament_winner();
               bred_gx[i] = next_draw() & 1 ? shadow_gx[p2] : shadow_gx[p1];
               bred_gy[i] = next_draw() & 1 ? shadow_gy[p2] : shadow_gy[p1];
               bred_fit[i] = 0;
            end
            // mutation pass after all crossovers
            for (int i = first; i < NSLOT; i++) begin
               if (next_draw() < mut_thresh) bred_gx[i] = bred_gx[i] + (next_draw() & 1);
               if (next_draw() < mut_thresh) bred_gy[i] = bred_gy[i] + (next_draw() & 1);
            end
            for (int i = 0; i < NSLOT; i++) begin
               shadow_gx[i] = bred_gx[i];
               shadow_gy[i] = bred_gy[i];
               shadow_fit[i] = bred_fit[i];
               expected_members.push_back('{i[3:0], bred_gx[i], bred_gy[i], bred_fit[i],
                                            i == NSLOT - 1});
            end
         end
      endcase
   endfunction

   // driver: everything changes on the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_type <= pending_reqs[0].kind;
            req_member_index <= pending_reqs[0].slot;
            req_gene_x <= pending_reqs[0].gx;
            req_gene_y <= pending_reqs[0].gy;
            req_fitness_value <= pending_reqs[0].fit;
            void'(pending_reqs.pop_front());
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: predict on request accept, check each accepted report
   always @(posedge clock) begin
      member_rpt_t got, want;
      req_taken <= req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         predict_members('{req_type, req_member_index, req_gene_x, req_gene_y,
                           req_fitness_value});
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_out_index, rsp_out_gene_x, rsp_out_gene_y, rsp_out_fitness, rsp_last};
         if (expected_members.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected report %p", got);
         end else begin
            want = expected_members.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("report mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ELITISM:    keep_elite = val[0];
         CSR_TOURNAMENT: tourney_draws = val[2:0];
         CSR_MUT_THR:    mut_thresh = val[15:0];
         default:        shadow_lfsr = (val == 0) ? 32'd1 : val;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_req(logic [1:0] k, logic [3:0] s, logic [15:0] x, logic [15:0] y,
                            logic [31:0] f);
      pending_reqs.push_back('{k, s, x, y, f});
   endtask

   // idle means nothing queued, nothing in flight and a quiet tail;
   // checked on rising edges so a request popped but not yet driven counts
   task automatic drain();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_members.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic queue_random(int count);
      int sel;
      logic [3:0] s;
      logic [31:0] f;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         // mostly valid slots, now and then an index past the population (10 to 15)
         s = ($urandom_range(9) == 0) ? 4'($urandom_range(15, NSLOT)) : 4'($urandom_range(NSLOT-1));
         // small fitness values often, so ties are common
         f = $urandom_range(2) == 0 ? 32'($urandom_range(3)) : $urandom;
         if (sel < 30)      queue_req(REQ_SET_FIT, s, 16'd0, 16'd0, f);
         else if (sel < 55) queue_req(REQ_LOAD, s, 16'($urandom), 16'($urandom), 32'd0);
         else if (sel < 78) queue_req(REQ_READ, 4'($urandom), 16'd0, 16'd0, 32'd0);
         else               queue_req(REQ_EVOLVE, 4'($urandom), 16'd0, 16'd0, 32'd0);
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0; req_type = REQ_LOAD; req_member_index = 0;
      req_gene_x = 0; req_gene_y = 0; req_fitness_value = 0;
      rsp_ready = 0; csr_valid = 0; csr_index = CSR_ELITISM; csr_wdata = 0;
      keep_elite = 1; tourney_draws = 5; mut_thresh = 983; shadow_lfsr = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // phase 0: reset defaults, no idling, directed opening
      csr_write(CSR_ELITISM, 32'd1);
      csr_write(CSR_TOURNAMENT, 32'd5);
      csr_write(CSR_MUT_THR, 32'd983);
      csr_write(CSR_SEED, 32'd1);
      // every slot gets genes and fitness before any read or evolve
      for (int i = 0; i < NSLOT; i++) begin
         queue_req(REQ_LOAD, 4'(i), (i == 0) ? 16'h8000 : (i == 1) ? 16'h7fff : 16'($urandom),
                   (i == 0) ? 16'h7fff : (i == 1) ? 16'hffff : 16'($urandom), 32'd0);
         queue_req(REQ_SET_FIT, 4'(i), 16'd0, 16'd0, (i == 0) ? 32'h8000_0000 :
                   (i == 1) ? 32'h7fff_ffff : (i == 5) ? 32'h7fff_ffff : 32'(i));
      end
      queue_req(REQ_READ, 4'd0, 16'd0, 16'd0, 32'd0);
      queue_req(REQ_LOAD, 4'd12, 16'h1234, 16'h5678, 32'd0);   // ignored, out of range
      queue_req(REQ_SET_FIT, 4'd15, 16'd0, 16'd0, 32'hdead_beef);  // ignored, out of range
      queue_req(REQ_READ, 4'd15, 16'd0, 16'd0, 32'd0);         // out of range read
      queue_req(REQ_EVOLVE, 4'd0, 16'd0, 16'd0, 32'd0);
      queue_req(REQ_READ, 4'd9, 16'd0, 16'd0, 32'd0);
      queue_random(40);
      drain();

      // phase 1: sender idles, no elitism, zero tournament, mutate on every draw below ffff, zero seed
      idle_pct = 59; stall_pct = 0;
      csr_write(CSR_ELITISM, 32'd0);
      csr_write(CSR_TOURNAMENT, 32'd0);
      csr_write(CSR_MUT_THR, 32'h0000_ffff);
      csr_write(CSR_SEED, 32'd0);
      queue_random(40);
      drain();

      // phase 2: receiver stalls, oversized tournament, never mutate, all-ones seed
      idle_pct = 0; stall_pct = 59;
      csr_write(CSR_ELITISM, 32'd1);
      csr_write(CSR_TOURNAMENT, 32'd7);
      csr_write(CSR_MUT_THR, 32'd0);
      csr_write(CSR_SEED, 32'hffff_ffff);
      queue_random(40);
      drain();

      // phase 3: both sides idle, random legal settings
      idle_pct = 13; stall_pct = 13;
      csr_write(CSR_ELITISM, 32'($urandom_range(1)));
      csr_write(CSR_TOURNAMENT, 32'($urandom_range(5, 1)));
      csr_write(CSR_MUT_THR, $urandom);
      csr_write(CSR_SEED, $urandom | 32'd1);
      queue_random(40);
      drain();

      if (mismatches == 0 && expected_members.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // hard stop if the engine hangs
   initial begin
      #60000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
